// ===== hdl/sert_pkg.sv =====
// Shared types and constants for the syscall errno rule table.
// Holds the beat token that walks the cell chain and the result codes.
// No dependencies.
package sert_pkg;

    localparam int NR_W    = 15;
    localparam int ERRNO_W = 12;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        CMD_SET,
        CMD_CHECK,
        CMD_CLEAR,
        CMD_FILL
    } t_cmd;

    // Token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic               vld;
        t_cmd               cmd;
        logic [NR_W-1:0]    nr;
        logic [ERRNO_W-1:0] val;   // error to write, or error found by a check
        logic               hit;   // match seen, or fill already taken
        logic               free;  // free slot seen
    } t_tok;

endpackage

// ===== hdl/sert_cell.sv =====
// One rule slot of the chain: valid bit, call number and error code.
// Looks at the passing token, updates its slot and hands the token on.
// Depends on sert_pkg.
module sert_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sert_pkg::t_tok i_tok,
    output sert_pkg::t_tok o_tok
);
    import sert_pkg::*;

    logic               r_valid;
    logic [NR_W-1:0]    r_nr;
    logic [ERRNO_W-1:0] r_errno;
    t_tok               r_tok;
    t_tok               n_tok;
    logic               match;
    logic               take;

    assign match = r_valid && (r_nr == i_tok.nr);
    assign take  = i_tok.vld && (i_tok.cmd == CMD_FILL) && !r_valid && !i_tok.hit;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld) begin
            case (i_tok.cmd)
                CMD_SET: begin
                    if (match) n_tok.hit = 1'b1;
                    if (!r_valid) n_tok.free = 1'b1;
                end
                CMD_CHECK: begin
                    if (match) begin
                        n_tok.hit = 1'b1;
                        n_tok.val = r_errno;
                    end
                end
                CMD_FILL: begin
                    if (take) n_tok.hit = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.vld && (i_tok.cmd == CMD_CLEAR)) r_valid <= 1'b0;
            else if (take) r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_nr    <= i_tok.nr;
            r_errno <= i_tok.val;
        end else if (i_tok.vld && (i_tok.cmd == CMD_SET) && match) begin
            r_errno <= i_tok.val;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hdl/syscall_errno_rule_table.sv =====
// Top level of the syscall errno rule table: command decode, result register
// and a chain of RULE_SLOTS rule cells. Depends on sert_pkg and sert_cell.
//
// channel   direction  handshake                  payload
// command   in         start high, busy low       i_op, i_syscall_nr, i_err_value
// result    out        o_strobe, one cycle        o_status, o_denied, o_deny_errno
//
// A command that fails its argument checks (negative call number or
// non-positive error on set, unused op) and a check of a negative number
// answer in the cycle after the command beat. Every other command walks the
// cell chain once, one cell per cycle; a set that adds a new rule walks it
// twice. The chain length sets the rate.
// Reset clears every valid bit at once; no clearing pass. The receiver
// cannot stall: the result beat is on the ports for exactly one cycle.
module syscall_errno_rule_table #(
    parameter int RULE_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_syscall_nr,
    input  logic signed [12:0] i_err_value,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic               o_denied,
    output logic [11:0]        o_deny_errno
);
    import sert_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state             r_state, n_state;
    t_tok               r_launch, n_launch;
    logic               r_strobe, n_strobe;
    logic [1:0]         r_status, n_status;
    logic               r_denied, n_denied;
    logic [ERRNO_W-1:0] r_deny_errno, n_deny_errno;

    t_tok               w_tok [RULE_SLOTS+1];
    t_tok               tail;
    logic               nr_neg;
    logic               err_pos;

    // Chain of cells: the launch register feeds the first, the last feeds back here.
    assign w_tok[0] = r_launch;
    for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
        sert_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end
    assign tail = w_tok[RULE_SLOTS];

    assign nr_neg  = i_syscall_nr[15];
    assign err_pos = !i_err_value[12] && (|i_err_value[11:0]);

    always_comb begin
        n_state      = r_state;
        n_launch     = '0;
        n_strobe     = 1'b0;
        n_status     = ST_OK;
        n_denied     = 1'b0;
        n_deny_errno = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    // Fill the token fields common to every launched command.
                    n_launch.nr  = i_syscall_nr[NR_W-1:0];
                    n_launch.val = i_err_value[ERRNO_W-1:0];
                    case (i_op)
                        OP_SET: begin
                            if (nr_neg || !err_pos) begin
                                n_strobe = 1'b1;
                                n_status = ST_INVALID;
                            end else begin
                                n_launch.vld = 1'b1;
                                n_launch.cmd = CMD_SET;
                                n_state      = S_WALK;
                            end
                        end
                        OP_CHECK: begin
                            // Stored numbers are never negative: allow at once.
                            if (nr_neg) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_launch.vld = 1'b1;
                                n_launch.cmd = CMD_CHECK;
                                n_launch.val = '0;
                                n_state      = S_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            n_launch.vld = 1'b1;
                            n_launch.cmd = CMD_CLEAR;
                            n_state      = S_WALK;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (tail.vld) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    case (tail.cmd)
                        CMD_SET: begin
                            if (!tail.hit) begin
                                if (tail.free) begin
                                    // No rule matched: walk again and take the lowest free slot.
                                    n_strobe     = 1'b0;
                                    n_state      = S_WALK;
                                    n_launch.vld = 1'b1;
                                    n_launch.cmd = CMD_FILL;
                                    n_launch.nr  = tail.nr;
                                    n_launch.val = tail.val;
                                end else begin
                                    n_status = ST_FULL;
                                end
                            end
                        end
                        CMD_CHECK: begin
                            n_denied     = tail.hit;
                            n_deny_errno = tail.hit ? tail.val : '0;
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_launch     <= '0;
            r_strobe     <= 1'b0;
            r_status     <= ST_OK;
            r_denied     <= 1'b0;
            r_deny_errno <= '0;
        end else begin
            r_state      <= n_state;
            r_launch     <= n_launch;
            r_strobe     <= n_strobe;
            r_status     <= n_status;
            r_denied     <= n_denied;
            r_deny_errno <= n_deny_errno;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_denied     = r_denied;
    assign o_deny_errno = r_deny_errno;

endmodule

// ===== hdl/sert_chk.sv =====
// Port-level checks for the syscall errno rule table, bound to the top level.
// Depends on sert_pkg and syscall_errno_rule_table.
module sert_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic        o_denied,
    input logic [11:0] o_deny_errno
);
    import sert_pkg::*;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command beat");

    a_deny_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_denied) |-> (o_status == ST_OK && o_deny_errno != 12'd0))
        else $error("deny beat with bad status or zero error");

    a_allow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_denied) |-> (o_deny_errno == 12'd0))
        else $error("allow beat with nonzero error");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status == ST_OK || o_status == ST_INVALID || o_status == ST_FULL))
        else $error("unknown status code");

endmodule

bind syscall_errno_rule_table sert_chk u_sert_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_status     (o_status),
    .o_denied     (o_denied),
    .o_deny_errno (o_deny_errno)
);
